[design/fmop_pkg.sv]
`timescale 1ns / 1ps
// Package for the FM operator pair oscillator: shared types, operation and
// register codes, fixed widths. No dependencies.
package fmop_pkg;

	localparam int PHASE_BITS = 24;
	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 64;
	localparam int MUL_A_W    = 18;
	localparam int MUL_B_W    = 33;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_WR_CAR  = 2'd1,
		OP_WR_MOD  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BASE_INC   = 3'd0,
		REG_CAR_RATIO  = 3'd1,
		REG_MOD_RATIO  = 3'd2,
		REG_MOD_INDEX  = 3'd3,
		REG_FB_AMOUNT  = 3'd4,
		REG_CAR_START  = 3'd5,
		REG_MOD_START  = 3'd6,
		REG_SPARE      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		SH_NONE = 2'd0,
		SH_14   = 2'd1,
		SH_32   = 2'd2
	} shift_sel_t;

	typedef struct packed {
		logic       en;
		logic       clear;
		shift_sel_t shift;
	} mac_ctrl_t;

endpackage

[design/fmop_in_if.sv]
`timescale 1ns / 1ps
// Input channel: tick and table write items, valid/ready handshake.
// Depends on fmop_pkg.
interface fmop_in_if import fmop_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic [11:0]                table_index;
	logic signed [SAMPLE_W-1:0] table_value;

	modport source (output valid, output operation, output table_index,
		output table_value, input ready);
	modport sink (input valid, input operation, input table_index,
		input table_value, output ready);
endinterface

[design/fmop_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one carrier sample per tick, valid/ready handshake.
// Depends on fmop_pkg.
interface fmop_out_if import fmop_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[design/fmop_wavetable.sv]
`timescale 1ns / 1ps
// Single wavetable RAM: one write port, one read port with registered data.
// Depends on fmop_pkg.
module fmop_wavetable import fmop_pkg::*; #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/fmop_mac.sv]
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: 18x33 signed product, shifted by a
// selectable amount and added into a 64-bit accumulator. Depends on fmop_pkg.
module fmop_mac import fmop_pkg::*; (
	input  logic                      clk,
	input  mac_ctrl_t                 ctrl,
	input  logic signed [MUL_A_W-1:0] op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	output logic [ACC_W-1:0]          acc
);

	localparam int PROD_W = MUL_A_W + MUL_B_W;

	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0]         prod_ext;
	logic [ACC_W-1:0]         addend;
	logic [ACC_W-1:0]         acc_q;

	assign prod     = op_a * op_b;
	assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_comb begin
		case (ctrl.shift)
			SH_14:   addend = prod_ext << 14;
			SH_32:   addend = prod_ext << 32;
			default: addend = prod_ext;
		endcase
	end

	// accumulator is payload; the sequencer always clears it before use
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.clear ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

[design/fm_operator_pair_oscillator_top.sv]
`timescale 1ns / 1ps
// Two-operator FM wavetable oscillator with modulator self-feedback.
// Depends on fmop_pkg, fmop_in_if, fmop_out_if, fmop_wavetable, fmop_mac.
//
// Table write items leave the block ready again at once. A tick item runs
// through twelve sequencer steps after acceptance until the sample is loaded
// into the output register, waiting in the last step only if the previous
// sample has not yet been taken. The step sequence is set
// by the single shared 18x33 multiply-accumulate unit: two interpolations,
// the feedback product, the modulator step, the 47x16 deviation product in
// two halves, the carrier base product and the 16x55 carrier modulation
// product in two halves each take one pass through it, plus the table reads
// around them. The input is not ready while a tick is in progress. A
// finished sample waits in its output register while the next item is taken.
module fm_operator_pair_oscillator_top import fmop_pkg::*; #(
	parameter int CARRIER_TABLE_DEPTH   = 4096,
	parameter int MODULATOR_TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	fmop_in_if.sink     in_ch,
	fmop_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	localparam int AWM = $clog2(MODULATOR_TABLE_DEPTH);
	localparam int AWC = $clog2(CARRIER_TABLE_DEPTH);
	localparam int LM  = PHASE_BITS - AWM;
	localparam int LC  = PHASE_BITS - AWC;
	localparam int IDX_EXT_W = 17;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_MRD0 = 13'b0000000000010,
		ST_MRD1 = 13'b0000000000100,
		ST_MINT = 13'b0000000001000,
		ST_MFIN = 13'b0000000010000,
		ST_FBK  = 13'b0000000100000,
		ST_CINT = 13'b0000001000000,
		ST_CFIN = 13'b0000010000000,
		ST_DM1  = 13'b0000100000000,
		ST_DMS  = 13'b0001000000000,
		ST_P1   = 13'b0010000000000,
		ST_P2   = 13'b0100000000000,
		ST_UPD  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [30:0]                base_inc_q;
	logic [15:0]                car_ratio_q;
	logic [15:0]                mod_ratio_q;
	logic [15:0]                mod_index_q;
	logic signed [15:0]         fb_amount_q;

	// oscillator state
	logic [PHASE_BITS-1:0]      car_phase_q;
	logic [PHASE_BITS-1:0]      mod_phase_q;
	logic signed [SAMPLE_W-1:0] prev_q;

	// working registers
	logic signed [SAMPLE_W-1:0] x0_q;
	logic signed [SAMPLE_W-1:0] m_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [46:0]                mstep_q;
	logic [54:0]                dm_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic                       in_acc;
	logic                       upd_go;
	logic [IDX_EXT_W-1:0]       idx_ext;

	logic                       mod_we, car_we;
	logic [AWM-1:0]             mod_raddr, mod_pos, mod_pos_raw, mod_nxt;
	logic [AWC-1:0]             car_raddr, car_pos, car_pos_raw, car_nxt;
	logic signed [SAMPLE_W-1:0] mod_rdata, car_rdata;
	logic [LM-1:0]              mod_frac;
	logic [LC-1:0]              car_frac;

	mac_ctrl_t                  mac_ctrl;
	logic signed [MUL_A_W-1:0]  op_a;
	logic signed [MUL_B_W-1:0]  op_b;
	logic [ACC_W-1:0]           acc;
	logic signed [ACC_W-1:0]    acc_m_sh, acc_c_sh;
	logic signed [16:0]         diff_m, diff_c;
	logic signed [31:0]         fb_sum;
	logic signed [17:0]         fb_full;
	logic signed [SAMPLE_W-1:0] fb_sat;

	assign in_acc       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.sample = out_q;
	assign upd_go       = (state_q == ST_UPD) && (!out_valid_q || out_ch.ready);

	// table writes; entries at or above the depth are dropped
	assign idx_ext = IDX_EXT_W'(in_ch.table_index);
	assign mod_we  = in_acc && (in_ch.operation == OP_WR_MOD)
		&& (idx_ext < IDX_EXT_W'(MODULATOR_TABLE_DEPTH));
	assign car_we  = in_acc && (in_ch.operation == OP_WR_CAR)
		&& (idx_ext < IDX_EXT_W'(CARRIER_TABLE_DEPTH));

	// read positions; a non power-of-two depth can overshoot by less than one depth
	always_comb begin
		mod_pos_raw = mod_phase_q[PHASE_BITS-1:LM];
		mod_pos     = mod_pos_raw;
		if ({1'b0, mod_pos_raw} >= (AWM+1)'(MODULATOR_TABLE_DEPTH)) begin
			mod_pos = mod_pos_raw - AWM'(MODULATOR_TABLE_DEPTH);
		end
		mod_nxt = (mod_pos == AWM'(MODULATOR_TABLE_DEPTH - 1)) ? '0 : mod_pos + 1'b1;
		mod_frac = mod_phase_q[LM-1:0];

		car_pos_raw = car_phase_q[PHASE_BITS-1:LC];
		car_pos     = car_pos_raw;
		if ({1'b0, car_pos_raw} >= (AWC+1)'(CARRIER_TABLE_DEPTH)) begin
			car_pos = car_pos_raw - AWC'(CARRIER_TABLE_DEPTH);
		end
		car_nxt = (car_pos == AWC'(CARRIER_TABLE_DEPTH - 1)) ? '0 : car_pos + 1'b1;
		car_frac = car_phase_q[LC-1:0];
	end

	assign mod_raddr = (state_q == ST_MRD0) ? mod_pos : mod_nxt;
	assign car_raddr = (state_q == ST_MFIN) ? car_pos : car_nxt;

	fmop_wavetable #(.DEPTH(MODULATOR_TABLE_DEPTH)) u_mod_table (
		.clk   (clk),
		.we    (mod_we),
		.waddr (idx_ext[AWM-1:0]),
		.wdata (in_ch.table_value),
		.raddr (mod_raddr),
		.rdata (mod_rdata)
	);

	fmop_wavetable #(.DEPTH(CARRIER_TABLE_DEPTH)) u_car_table (
		.clk   (clk),
		.we    (car_we),
		.waddr (idx_ext[AWC-1:0]),
		.wdata (in_ch.table_value),
		.raddr (car_raddr),
		.rdata (car_rdata)
	);

	assign diff_m   = {mod_rdata[SAMPLE_W-1], mod_rdata} - {x0_q[SAMPLE_W-1], x0_q};
	assign diff_c   = {car_rdata[SAMPLE_W-1], car_rdata} - {x0_q[SAMPLE_W-1], x0_q};
	assign acc_m_sh = $signed(acc) >>> LM;
	assign acc_c_sh = $signed(acc) >>> LC;

	// feedback: floor((m*2^13 + prev*amount) / 2^14), saturated
	assign fb_sum  = $signed(acc[31:0]) + $signed({{3{m_q[SAMPLE_W-1]}}, m_q, 13'b0});
	assign fb_full = fb_sum[31:14];
	always_comb begin
		if (fb_full[17:15] == 3'b000 || fb_full[17:15] == 3'b111) begin
			fb_sat = fb_full[SAMPLE_W-1:0];
		end else if (fb_full[17]) begin
			fb_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			fb_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// operand selection for the shared MAC
	always_comb begin
		mac_ctrl = '{en: 1'b0, clear: 1'b0, shift: SH_NONE};
		op_a     = '0;
		op_b     = '0;
		unique case (state_q)
			ST_MINT: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
				op_a     = {diff_m[16], diff_m};
				op_b     = $signed(MUL_B_W'(mod_frac));
			end
			ST_MFIN: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
				op_a     = {{2{prev_q[SAMPLE_W-1]}}, prev_q};
				op_b     = {{17{fb_amount_q[15]}}, fb_amount_q};
			end
			ST_FBK: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
				op_a     = {2'b00, mod_ratio_q};
				op_b     = {2'b00, base_inc_q};
			end
			ST_CINT: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
				op_a     = {diff_c[16], diff_c};
				op_b     = $signed(MUL_B_W'(car_frac));
			end
			ST_CFIN: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
				op_a     = {2'b00, mod_index_q};
				op_b     = {1'b0, mstep_q[31:0]};
			end
			ST_DM1: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_32};
				op_a     = {2'b00, mod_index_q};
				op_b     = $signed(MUL_B_W'(mstep_q[46:32]));
			end
			ST_DMS: begin
				// carrier base term pre-scaled by 2^14 to share the 2^30 floor
				mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_14};
				op_a     = {2'b00, car_ratio_q};
				op_b     = {2'b00, base_inc_q};
			end
			ST_P1: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_NONE};
				op_a     = {{2{prev_q[SAMPLE_W-1]}}, prev_q};
				op_b     = {1'b0, dm_q[31:0]};
			end
			ST_P2: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_32};
				op_a     = {{2{prev_q[SAMPLE_W-1]}}, prev_q};
				op_b     = $signed(MUL_B_W'(dm_q[54:32]));
			end
			default: ;
		endcase
	end

	fmop_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && in_ch.operation == OP_TICK) state_d = ST_MRD0;
			ST_MRD0: state_d = ST_MRD1;
			ST_MRD1: state_d = ST_MINT;
			ST_MINT: state_d = ST_MFIN;
			ST_MFIN: state_d = ST_FBK;
			ST_FBK:  state_d = ST_CINT;
			ST_CINT: state_d = ST_CFIN;
			ST_CFIN: state_d = ST_DM1;
			ST_DM1:  state_d = ST_DMS;
			ST_DMS:  state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_UPD;
			ST_UPD:  if (upd_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_inc_q  <= 31'd39370577;
			car_ratio_q <= 16'd256;
			mod_ratio_q <= 16'd256;
			mod_index_q <= 16'd256;
			fb_amount_q <= '0;
			car_phase_q <= '0;
			mod_phase_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_INC:  base_inc_q  <= cfg_wdata;
				REG_CAR_RATIO: car_ratio_q <= cfg_wdata[15:0];
				REG_MOD_RATIO: mod_ratio_q <= cfg_wdata[15:0];
				REG_MOD_INDEX: mod_index_q <= cfg_wdata[15:0];
				REG_FB_AMOUNT: fb_amount_q <= cfg_wdata[15:0];
				REG_CAR_START: car_phase_q <= cfg_wdata[PHASE_BITS-1:0];
				REG_MOD_START: mod_phase_q <= cfg_wdata[PHASE_BITS-1:0];
				default: ;
			endcase
		end else if (upd_go) begin
			car_phase_q <= car_phase_q + acc[30 +: PHASE_BITS];
			mod_phase_q <= mod_phase_q + mstep_q[16 +: PHASE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (state_q == ST_FBK) begin
			prev_q <= fb_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MRD1 || state_q == ST_FBK) begin
			x0_q <= (state_q == ST_MRD1) ? mod_rdata : car_rdata;
		end
		if (state_q == ST_MFIN) begin
			m_q <= x0_q + acc_m_sh[SAMPLE_W-1:0];
		end
		if (state_q == ST_CINT) begin
			mstep_q <= acc[46:0];
		end
		if (state_q == ST_CFIN) begin
			sample_q <= x0_q + acc_c_sh[SAMPLE_W-1:0];
		end
		if (state_q == ST_DMS) begin
			dm_q <= acc[62:8];
		end
		if (upd_go) begin
			out_q <= sample_q;
		end
	end

endmodule

[design/fmop_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the FM operator pair oscillator, bound to the top.
// Depends on fmop_pkg and fm_operator_pair_oscillator_top.
module fmop_checker import fmop_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [1:0]                 in_operation,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] out_sample
);

	// a held sample stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("output item changed or dropped while stalled");

	// a tick occupies the block
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_operation == OP_TICK |=> !in_ready)
		else $error("input ready straight after a tick item");

	// table writes and no-ops never occupy the block
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_operation == OP_WR_CAR
			|| in_operation == OP_WR_MOD || in_operation == OP_NONE) |=> in_ready)
		else $error("input not ready after a non-tick item");

	// a new sample only appears at the end of a tick
	a_sample_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output item raised while idle");

endmodule

bind fm_operator_pair_oscillator_top fmop_checker u_fmop_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_operation (in_ch.operation),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_sample   (out_ch.sample)
);
